[hw/rtl/bdy_pkg.sv]
// Buddy allocator package: opcodes, beat and config structs, bit helpers.
// No dependencies; used by bdy_core and buddy_allocator.
package bdy_pkg;

  localparam int unsigned SIZE_W = 17;
  localparam int unsigned OFFS_W = 16;
  localparam int unsigned LVL_W  = 5;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned WORD_W = 64;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } bdy_op_t;

  typedef enum logic [1:0] {
    REG_HEAP_BYTES = 2'd0,
    REG_MIN_LEVEL  = 2'd1,
    REG_MAX_LEVEL  = 2'd2
  } bdy_reg_t;

  // Effective configuration, already clamped
  typedef struct packed {
    logic [SIZE_W-1:0] hb;
    logic [LVL_W-1:0]  mn;
    logic [LVL_W-1:0]  mx;
  } bdy_cfg_t;

  typedef struct packed {
    bdy_op_t           op;
    logic [SIZE_W-1:0] size;
    logic [OFFS_W-1:0] offs;
  } bdy_req_t;

  typedef struct packed {
    logic              ok;
    logic [OFFS_W-1:0] alloc_offset;
    logic [CNT_W-1:0]  frag_total;
    logic [CNT_W-1:0]  free_blocks;
    logic [CNT_W-1:0]  free_bytes;
  } bdy_res_t;

  // Bits lo_a .. hi_a-1 set; amounts run 0..64
  function automatic logic [WORD_W-1:0] range_mask(logic [6:0] lo_a, logic [6:0] hi_a);
    logic [WORD_W-1:0] lm;
    logic [WORD_W-1:0] hm;
    lm = lo_a[6] ? '0 : ({WORD_W{1'b1}} << lo_a[5:0]);
    hm = hi_a[6] ? '1 : ~({WORD_W{1'b1}} << hi_a[5:0]);
    return lm & hm;
  endfunction

  function automatic logic [5:0] lsb_index(logic [WORD_W-1:0] w);
    logic [5:0] idx;
    idx = '0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (w[k]) idx = 6'(k);
    end
    return idx;
  endfunction

  function automatic logic [LVL_W-1:0] ceil_log2(logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] m;
    logic [LVL_W-1:0]  r;
    m = n - SIZE_W'(1);
    r = '0;
    if (n > SIZE_W'(1)) begin
      for (int k = 0; k < SIZE_W; k++) begin
        if (m[k]) r = LVL_W'(k + 1);
      end
    end
    return r;
  endfunction

  // 2^lv modulo 2^17
  function automatic logic [CNT_W-1:0] pow2_cnt(logic [LVL_W-1:0] lv);
    return CNT_W'(1) << lv;
  endfunction

endpackage

[hw/rtl/bdy_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bdy_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/bdy_core.sv]
// Buddy allocator engine: sequencer over the free bitmap RAM and running totals.
// Depends on bdy_pkg and bdy_ram.
module bdy_core
  import bdy_pkg::*;
#(
  parameter int unsigned HEAP_LOG2 = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  bdy_cfg_t cfg,
  input  bdy_req_t req,
  input  logic     start,
  output logic     ready,
  output bdy_res_t res,
  output logic     res_valid,
  input  logic     res_take
);

  localparam int unsigned OW = HEAP_LOG2;
  localparam int unsigned PW = HEAP_LOG2 + 1;
  localparam int unsigned NW = 2 ** (HEAP_LOG2 - 5);
  localparam int unsigned AW = HEAP_LOG2 - 5;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CLEAR = 10'b0000000010,
    S_ILEV  = 10'b0000000100,
    S_MRD   = 10'b0000001000,
    S_MWR   = 10'b0000010000,
    S_SCAN  = 10'b0000100000,
    S_SPLIT = 10'b0001000000,
    S_FRD   = 10'b0010000000,
    S_FCHK  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  function automatic logic [PW-1:0] lvl_base(logic [LVL_W-1:0] lv);
    logic [PW:0] full;
    full     = '0;
    full[PW] = 1'b1;
    return PW'(full - (full >> lv));
  endfunction

  function automatic logic [PW-1:0] lvl_end(logic [LVL_W-1:0] lv);
    logic [PW:0] full;
    full     = '0;
    full[PW] = 1'b1;
    return lvl_base(lv) + PW'((full >> lv) >> 1);
  endfunction

  function automatic logic [PW-1:0] bit_pos(logic [LVL_W-1:0] lv, logic [OW-1:0] off);
    return lvl_base(lv) + PW'(off >> lv);
  endfunction

  // Distance from word start lo to x, clamped to 0..64
  function automatic logic [6:0] span(logic [PW-1:0] x, logic [PW-1:0] lo);
    logic [PW-1:0] d;
    d = x - lo;
    if (x <= lo) return 7'd0;
    else if (d > PW'(63)) return 7'd64;
    else return d[6:0];
  endfunction

  state_t            state_r, state_nxt;
  bdy_op_t           op_r, op_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [LVL_W-1:0]  lv_r, lv_nxt;
  logic [LVL_W-1:0]  tgt_r, tgt_nxt;
  logic [OW-1:0]     off_r, off_nxt;
  logic [OW-1:0]     moff_r, moff_nxt;
  logic [AW-1:0]     word_r, word_nxt;
  logic [AW-1:0]     chk_w_r, chk_w_nxt;
  logic              chk_v_r, chk_v_nxt;
  logic [PW-1:0]     fb_r, fb_nxt;
  logic [PW-1:0]     fe_r, fe_nxt;
  logic              ok_r, ok_nxt;
  logic [CNT_W-1:0]  frag_r, frag_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  sum_r, sum_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  bdy_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NW)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Request decode
  logic [LVL_W-1:0]  req_lv;
  logic [OW-1:0]     req_off;
  logic [SIZE_W-1:0] init_cnt;

  always_comb begin
    req_lv   = ceil_log2(req.size);
    if (req_lv < cfg.mn) req_lv = cfg.mn;
    req_off  = OW'(req.offs);
    req_off  = (req_off >> req_lv) << req_lv;
    init_cnt = cfg.hb >> cfg.mx;
  end

  // Scan and RMW addressing
  logic [PW-1:0]     cur_base, cur_end, cur_last, chk_lo, mpos, bpos;
  logic [WORD_W-1:0] chk_word;
  logic [5:0]        chk_k;
  logic [OW-1:0]     bud_off;

  always_comb begin
    cur_base = lvl_base(lv_r);
    cur_end  = lvl_end(lv_r);
    cur_last = cur_end - PW'(1);
    chk_lo   = {chk_w_r, 6'b0};
    chk_word = ram_rdata & range_mask(span(cur_base, chk_lo), span(cur_end, chk_lo));
    chk_k    = lsb_index(chk_word);
    mpos     = bit_pos(lv_r, moff_r);
    bud_off  = off_r ^ (OW'(1) << lv_r);
    bpos     = bit_pos(lv_r, bud_off);
  end

  always_comb begin
    logic [PW-1:0] lo_c;
    logic [PW-1:0] rel;
    logic [PW-1:0] nb;
    lo_c = {word_r, 6'b0};
    rel  = '0;
    nb   = '0;

    state_nxt = state_r;
    op_nxt    = op_r;
    size_nxt  = size_r;
    lv_nxt    = lv_r;
    tgt_nxt   = tgt_r;
    off_nxt   = off_r;
    moff_nxt  = moff_r;
    word_nxt  = word_r;
    chk_w_nxt = chk_w_r;
    chk_v_nxt = chk_v_r;
    fb_nxt    = fb_r;
    fe_nxt    = fe_r;
    ok_nxt    = ok_r;
    frag_nxt  = frag_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;

    ram_we    = 1'b0;
    ram_waddr = word_r;
    ram_wdata = '0;
    ram_raddr = word_r;
    ready     = 1'b0;
    res_valid = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        ready = 1'b1;
        if (start) begin
          op_nxt   = req.op;
          size_nxt = req.size;
          ok_nxt   = 1'b0;
          case (req.op)
            OP_INIT: begin
              frag_nxt  = '0;
              cnt_nxt   = init_cnt;
              sum_nxt   = (init_cnt << cfg.mx);
              fb_nxt    = lvl_base(cfg.mx);
              fe_nxt    = lvl_base(cfg.mx) + PW'(init_cnt);
              word_nxt  = '0;
              lv_nxt    = cfg.mx;
              state_nxt = S_CLEAR;
            end
            OP_ALLOC: begin
              if (req_lv > cfg.mx) begin
                state_nxt = S_DONE;
              end else begin
                lv_nxt    = req_lv;
                tgt_nxt   = req_lv;
                nb        = lvl_base(req_lv);
                word_nxt  = nb[PW-1:6];
                chk_v_nxt = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            OP_FREE: begin
              if (req_lv > cfg.mx) begin
                state_nxt = S_DONE;
              end else begin
                frag_nxt = frag_r - (pow2_cnt(req_lv) - req.size);
                lv_nxt   = req_lv;
                off_nxt  = req_off;
                moff_nxt = req_off;
                state_nxt = (req_lv < cfg.mx) ? S_FRD : S_MRD;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // Sweep every word, laying in the top-level run on init
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = range_mask(span(fb_r, lo_c), span(fe_r, lo_c));
        word_nxt  = word_r + AW'(1);
        if (word_r == {AW{1'b1}}) state_nxt = (op_r == OP_INIT) ? S_ILEV : S_IDLE;
      end

      S_ILEV: begin
        if (lv_r == cfg.mn) begin
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          lv_nxt = lv_r - LVL_W'(1);
          if (cfg.hb[lv_nxt] && lv_nxt < LVL_W'(SIZE_W)) begin
            moff_nxt  = OW'((cfg.hb >> lv_r) << lv_r);
            state_nxt = S_MRD;
          end
        end
      end

      S_MRD: begin
        ram_raddr = mpos[PW-1:6];
        state_nxt = S_MWR;
      end

      S_MWR: begin
        ram_we    = 1'b1;
        ram_waddr = mpos[PW-1:6];
        ram_wdata = ram_rdata | (WORD_W'(1) << mpos[5:0]);
        if (!ram_rdata[mpos[5:0]]) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          sum_nxt = sum_r + pow2_cnt(lv_r);
        end
        case (op_r)
          OP_INIT:  state_nxt = S_ILEV;
          OP_ALLOC: state_nxt = S_SPLIT;
          default: begin
            ok_nxt    = 1'b1;
            state_nxt = S_DONE;
          end
        endcase
      end

      // One read issued per cycle, checked in the cycle after
      S_SCAN: begin
        ram_raddr = word_r;
        word_nxt  = word_r + AW'(1);
        chk_w_nxt = word_r;
        chk_v_nxt = 1'b1;
        if (chk_v_r) begin
          if (chk_word != '0) begin
            rel       = chk_lo + PW'(chk_k) - cur_base;
            off_nxt   = OW'(rel) << lv_r;
            ram_we    = 1'b1;
            ram_waddr = chk_w_r;
            ram_wdata = ram_rdata & ~(WORD_W'(1) << chk_k);
            cnt_nxt   = cnt_r - CNT_W'(1);
            sum_nxt   = sum_r - pow2_cnt(lv_r);
            state_nxt = S_SPLIT;
          end else if (chk_w_r == cur_last[PW-1:6]) begin
            if (lv_r == cfg.mx) begin
              state_nxt = S_DONE;
            end else begin
              lv_nxt    = lv_r + LVL_W'(1);
              nb        = lvl_base(lv_nxt);
              word_nxt  = nb[PW-1:6];
              chk_v_nxt = 1'b0;
            end
          end
        end
      end

      // Hand back the upper halves, largest first
      S_SPLIT: begin
        if (lv_r == tgt_r) begin
          frag_nxt  = frag_r + pow2_cnt(tgt_r) - size_r;
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          lv_nxt    = lv_r - LVL_W'(1);
          moff_nxt  = off_r | (OW'(1) << lv_nxt);
          state_nxt = S_MRD;
        end
      end

      S_FRD: begin
        ram_raddr = bpos[PW-1:6];
        state_nxt = S_FCHK;
      end

      // Merge with a free buddy and climb, or stop and mark
      S_FCHK: begin
        if (ram_rdata[bpos[5:0]]) begin
          ram_we    = 1'b1;
          ram_waddr = bpos[PW-1:6];
          ram_wdata = ram_rdata & ~(WORD_W'(1) << bpos[5:0]);
          cnt_nxt   = cnt_r - CNT_W'(1);
          sum_nxt   = sum_r - pow2_cnt(lv_r);
          off_nxt   = off_r & ~(OW'(1) << lv_r);
          moff_nxt  = off_nxt;
          lv_nxt    = lv_r + LVL_W'(1);
          state_nxt = (lv_nxt < cfg.mx) ? S_FRD : S_MRD;
        end else begin
          moff_nxt  = off_r;
          state_nxt = S_MRD;
        end
      end

      S_DONE: begin
        if (res_take) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      op_r    <= OP_NOP;
      word_r  <= '0;
      chk_v_r <= 1'b0;
      fb_r    <= '0;
      fe_r    <= '0;
      ok_r    <= 1'b0;
      frag_r  <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      word_r  <= word_nxt;
      chk_v_r <= chk_v_nxt;
      fb_r    <= fb_nxt;
      fe_r    <= fe_nxt;
      ok_r    <= ok_nxt;
      frag_r  <= frag_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    lv_r    <= lv_nxt;
    tgt_r   <= tgt_nxt;
    off_r   <= off_nxt;
    moff_r  <= moff_nxt;
    chk_w_r <= chk_w_nxt;
  end

  logic [31:0] off_wide;
  assign off_wide = 32'(off_r);

  always_comb begin
    res.ok           = ok_r;
    res.alloc_offset = (ok_r && op_r == OP_ALLOC) ? off_wide[OFFS_W-1:0] : '0;
    res.frag_total   = frag_r;
    res.free_blocks  = cnt_r;
    res.free_bytes   = sum_r;
  end

`ifndef ASSERT_OFF
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> ready)
    else $error("result handed off but engine not idle");

  a_split_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPLIT) |-> ((off_r & ((OW'(1) << lv_r) - OW'(1))) == '0))
    else $error("allocated block not aligned to its level");

  a_merge_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FRD) |-> (lv_r < cfg.mx))
    else $error("buddy merge above the top level");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == S_IDLE))
    else $error("request taken while busy");
`endif

endmodule

[hw/rtl/buddy_allocator.sv]
// Buddy allocator top: stream ports, config registers and output beat register.
// Init sweeps every bitmap RAM word, then steps down the levels to the minimum, marking a
// block on each level whose bit is set in heap_bytes. Alloc scans the bitmap from the request
// level upward, then splits down; free merges free buddies upward, then marks the block.
// One item is worked at a time. After reset all 2^(HEAP_LOG2-5) bitmap words (2048 by
// default) are cleared with in_tready low; config writes are taken throughout.
module buddy_allocator
  import bdy_pkg::*;
#(
  parameter int unsigned HEAP_LOG2 = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[1:0], request_size[18:2], block_offset[34:19], zero fill
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // ok[0], alloc_offset[16:1], frag_total[33:17], free_blocks[50:34],
  // free_bytes[67:51], zero fill
  output logic [71:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_waddr,
  input  logic [16:0] cfg_wdata
);

  localparam logic [24:0] HEAP_SIZE = 25'(1) << HEAP_LOG2;
  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(HEAP_LOG2);

  logic [SIZE_W-1:0] heap_bytes_r;
  logic [LVL_W-1:0]  min_level_r;
  logic [LVL_W-1:0]  max_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_bytes_r <= SIZE_W'(65536);
      min_level_r  <= LVL_W'(4);
      max_level_r  <= LVL_W'(12);
    end else if (cfg_we) begin
      unique case (cfg_waddr)
        REG_HEAP_BYTES: heap_bytes_r <= cfg_wdata;
        REG_MIN_LEVEL:  min_level_r  <= cfg_wdata[LVL_W-1:0];
        REG_MAX_LEVEL:  max_level_r  <= cfg_wdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  bdy_cfg_t cfg;
  always_comb begin
    cfg.mn = (min_level_r > TOP_LVL) ? TOP_LVL : min_level_r;
    cfg.mx = (max_level_r > TOP_LVL) ? TOP_LVL : max_level_r;
    if (cfg.mx < cfg.mn) cfg.mx = cfg.mn;
    cfg.hb = ({8'b0, heap_bytes_r} > HEAP_SIZE) ? HEAP_SIZE[SIZE_W-1:0] : heap_bytes_r;
  end

  bdy_req_t req;
  assign req.op   = bdy_op_t'(in_tdata[1:0]);
  assign req.size = in_tdata[18:2];
  assign req.offs = in_tdata[34:19];

  logic     core_ready;
  logic     res_valid;
  logic     res_take;
  bdy_res_t res;

  logic        out_tvalid_r;
  logic [71:0] out_tdata_r;

  assign in_tready = core_ready;
  assign res_take  = !out_tvalid_r || out_tready;

  bdy_core #(
    .HEAP_LOG2(HEAP_LOG2)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .req      (req),
    .start    (in_tvalid && core_ready),
    .ready    (core_ready),
    .res      (res),
    .res_valid(res_valid),
    .res_take (res_take)
  );

  // Hold the beat until taken; refill in the same cycle it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_valid) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_tdata_r <= {4'b0, res.free_bytes, res.free_blocks, res.frag_total,
                      res.alloc_offset, res.ok};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
